@@ rtl/core/fca_pkg.sv @@
// Shared types, constants and codes of the chain allocator.
`timescale 1ns / 1ps

package fca_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 1024;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned BLOCK_W        = 10;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned STATUS_W       = 2;

  localparam logic [COUNT_W-1:0] MAX_CHAIN_RST = 11'd128;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_TRUNC  = 2'd2,
    OP_FOLLOW = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_OVERMAX = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_ALLOC_END,
    S_WALK,
    S_WALK_END,
    S_FOLLOW,
    S_RESP
  } state_t;

endpackage

@@ rtl/core/fca_if.sv @@
// Request and response channel interfaces of the chain allocator.
`timescale 1ns / 1ps

interface fca_req_if;
  logic                         valid;
  logic                         ready;
  logic [fca_pkg::OP_W-1:0]     operation;
  logic [fca_pkg::BLOCK_W-1:0]  block;
  logic [fca_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output operation, output block, output count, input ready);
  modport sink   (input valid, input operation, input block, input count, output ready);
endinterface

interface fca_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fca_pkg::STATUS_W-1:0]  status;
  logic [fca_pkg::BLOCK_W-1:0]   block_out;
  logic [fca_pkg::COUNT_W-1:0]   count_out;
  logic                          chain_end;

  modport source (output valid, output status, output block_out, output count_out,
                  output chain_end, input ready);
  modport sink   (input valid, input status, input block_out, input count_out,
                  input chain_end, output ready);
endinterface

@@ rtl/core/fca_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fca_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fat_chain_allocator_top.sv @@
// Top level of the file allocation table chain allocator.
`timescale 1ns / 1ps

// File allocation table chain allocator. The table holds one entry per disk
// block (free, end of chain, or next block) in a single RAM with one write and
// one registered read port, and a small sequencer walks it one entry per
// cycle. Allocate scans upward from block 0 and stops early when the requested
// blocks are found; free and truncate walk the chain from the given block, and
// a walk that stops on a free entry reads that entry too; follow reads the
// given block's entry; a rejected or out-of-range request goes straight to the
// response state. The registered RAM read port paces the sequencer: each step
// waits for the entry read in the step before, since a chain walk reads at the
// address the last entry held. One request is in flight at a time and
// in_req.ready is high only between requests. The result sits in an output
// register, so the next request is taken while the last result waits. After
// reset a clearing pass marks every entry free with in_req.ready low;
// cfg_wr_en writes max_chain_blocks (max_r); the user is to write it only
// while the block is idle, as the block itself does not enforce this.

module fat_chain_allocator_top #(
  parameter int unsigned NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fca_req_if.sink                      in_req,
  fca_rsp_if.source                    out_rsp,
  input  logic                         cfg_wr_en,
  input  logic [fca_pkg::COUNT_W-1:0]  cfg_wr_data
);

  localparam int unsigned BLK_W  = $clog2(NUM_BLOCKS);
  localparam int unsigned E_W    = $clog2(NUM_BLOCKS + 2);
  localparam int unsigned STEP_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW     = fca_pkg::COUNT_W;

  localparam logic [E_W-1:0]    END_MARK  = E_W'(NUM_BLOCKS);
  localparam logic [E_W-1:0]    FREE_MARK = E_W'(NUM_BLOCKS + 1);
  localparam logic [BLK_W-1:0]  LAST_IDX  = BLK_W'(NUM_BLOCKS - 1);
  localparam logic [STEP_W-1:0] STEP_MAX  = STEP_W'(NUM_BLOCKS);

  fca_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]     max_r;
  logic [BLK_W-1:0]  idx_r, idx_nxt;       // scan index, walk cursor, clear pointer
  logic [BLK_W-1:0]  prev_r, prev_nxt;     // last linked or last kept block
  logic [BLK_W-1:0]  first_r, first_nxt;
  logic [CW-1:0]     count_r, count_nxt;   // blocks requested or kept
  logic [CW-1:0]     done_r, done_nxt;     // blocks linked or kept so far
  logic [CW-1:0]     freed_r, freed_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              byp_r, byp_nxt;
  logic [E_W-1:0]    byp_data_r, byp_data_nxt;

  logic                             res_end_r, res_end_nxt;
  logic [fca_pkg::STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [fca_pkg::BLOCK_W-1:0]      res_block_r, res_block_nxt;
  logic [CW-1:0]                    res_count_r, res_count_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [fca_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [fca_pkg::BLOCK_W-1:0]      out_block_r, out_block_nxt;
  logic [CW-1:0]                    out_count_r, out_count_nxt;
  logic                             out_end_r, out_end_nxt;

  logic              ram_we;
  logic [BLK_W-1:0]  ram_waddr, ram_raddr;
  logic [E_W-1:0]    ram_wdata, ram_rdata;

  logic              in_fire, blk_in_range, slot_free, scan_done, walk_done;
  logic [E_W-1:0]    ent;
  logic [BLK_W-1:0]  ent_succ;
  logic [CW-1:0]     done_inc, freed_inc;
  logic [STEP_W-1:0] steps_inc;
  fca_pkg::op_t      op;

  fca_ram #(
    .WIDTH (E_W),
    .DEPTH (NUM_BLOCKS)
  ) u_fca_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready  = (state_r == fca_pkg::S_IDLE);
  assign in_fire       = in_req.valid && in_req.ready;
  assign op            = fca_pkg::op_t'(in_req.operation);
  assign blk_in_range  = 32'(in_req.block) < NUM_BLOCKS;
  assign slot_free     = !out_valid_r || out_rsp.ready;

  // Entry read last cycle; take the written value if that cycle also wrote it.
  assign ent       = byp_r ? byp_data_r : ram_rdata;
  assign ent_succ  = ent[BLK_W-1:0];
  assign done_inc  = done_r + 1'b1;
  assign freed_inc = freed_r + 1'b1;
  assign steps_inc = steps_r + 1'b1;

  // Allocate ends when enough blocks are linked or the top block was scanned.
  assign scan_done = ((ent == FREE_MARK) && (done_inc == count_r)) || (idx_r == LAST_IDX);
  // Walk ends after a block whose entry is not a successor, or at the step limit.
  assign walk_done = (ent >= END_MARK) || (steps_inc == STEP_MAX);

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.block_out = out_block_r;
  assign out_rsp.count_out = out_count_r;
  assign out_rsp.chain_end = out_end_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fca_pkg::S_CLEAR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = fca_pkg::S_IDLE;
        end
      end
      fca_pkg::S_IDLE: begin
        if (in_fire) begin
          case (op)
            fca_pkg::OP_ALLOC: begin
              if (in_req.count > max_r || in_req.count == '0) begin
                state_nxt = fca_pkg::S_RESP;
              end else begin
                state_nxt = fca_pkg::S_ALLOC;
              end
            end
            fca_pkg::OP_FREE, fca_pkg::OP_TRUNC: begin
              state_nxt = blk_in_range ? fca_pkg::S_WALK : fca_pkg::S_RESP;
            end
            default: begin
              state_nxt = blk_in_range ? fca_pkg::S_FOLLOW : fca_pkg::S_RESP;
            end
          endcase
        end
      end
      fca_pkg::S_ALLOC: begin
        if (scan_done) begin
          state_nxt = fca_pkg::S_ALLOC_END;
        end
      end
      fca_pkg::S_ALLOC_END: state_nxt = fca_pkg::S_RESP;
      fca_pkg::S_WALK: begin
        if (ent == FREE_MARK || walk_done) begin
          state_nxt = fca_pkg::S_WALK_END;
        end
      end
      fca_pkg::S_WALK_END: state_nxt = fca_pkg::S_RESP;
      fca_pkg::S_FOLLOW:   state_nxt = fca_pkg::S_RESP;
      fca_pkg::S_RESP: begin
        if (slot_free) begin
          state_nxt = fca_pkg::S_IDLE;
        end
      end
      default: state_nxt = fca_pkg::S_CLEAR;
    endcase
  end

  // Datapath, table port and result
  always_comb begin
    idx_nxt        = idx_r;
    prev_nxt       = prev_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    done_nxt       = done_r;
    freed_nxt      = freed_r;
    steps_nxt      = steps_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    res_count_nxt  = res_count_r;
    res_end_nxt    = res_end_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = FREE_MARK;
    ram_raddr      = idx_r;

    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_count_nxt  = out_count_r;
    out_end_nxt    = out_end_r;

    case (state_r)
      fca_pkg::S_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt = '0;
        end
      end
      fca_pkg::S_IDLE: begin
        res_status_nxt = fca_pkg::STATUS_OK;
        res_block_nxt  = '0;
        res_count_nxt  = '0;
        res_end_nxt    = 1'b1;
        done_nxt       = '0;
        freed_nxt      = '0;
        steps_nxt      = '0;
        first_nxt      = '0;
        count_nxt      = in_req.count;
        case (op)
          fca_pkg::OP_ALLOC: begin
            if (in_req.count > max_r) begin
              res_status_nxt = fca_pkg::STATUS_OVERMAX;
            end
            idx_nxt   = '0;
            ram_raddr = '0;
          end
          fca_pkg::OP_FREE, fca_pkg::OP_TRUNC: begin
            if (op == fca_pkg::OP_FREE) begin
              count_nxt = '0;
            end
            idx_nxt   = BLK_W'(in_req.block);
            ram_raddr = BLK_W'(in_req.block);
          end
          default: begin
            // out-of-range follow reads as a free entry
            res_end_nxt = 1'b0;
            ram_raddr   = BLK_W'(in_req.block);
          end
        endcase
      end
      fca_pkg::S_ALLOC: begin
        // Link a free block behind the previous one; its own entry gets the link
        // when the next free block is found, or the end mark at the end.
        if (ent == FREE_MARK) begin
          done_nxt = done_inc;
          prev_nxt = idx_r;
          if (done_r == '0) begin
            first_nxt = idx_r;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_r;
            ram_wdata = E_W'(idx_r);
          end
        end
        idx_nxt   = idx_r + 1'b1;
        ram_raddr = idx_r + 1'b1;
      end
      fca_pkg::S_ALLOC_END: begin
        if (done_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = prev_r;
          ram_wdata = END_MARK;
        end
        res_status_nxt = (done_r < count_r) ? fca_pkg::STATUS_NOSPACE : fca_pkg::STATUS_OK;
        res_block_nxt  = fca_pkg::BLOCK_W'(first_r);
        res_count_nxt  = done_r;
        res_end_nxt    = (done_r == '0);
      end
      fca_pkg::S_WALK: begin
        if (ent != FREE_MARK) begin
          steps_nxt = steps_inc;
          if (done_r < count_r) begin
            done_nxt = done_inc;
            prev_nxt = idx_r;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = idx_r;
            ram_wdata = FREE_MARK;
            freed_nxt = freed_inc;
          end
          if (!walk_done) begin
            idx_nxt   = ent_succ;
            ram_raddr = ent_succ;
          end
        end
      end
      fca_pkg::S_WALK_END: begin
        // Close the chain at the last kept block.
        if (done_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = prev_r;
          ram_wdata = END_MARK;
        end
        res_count_nxt = freed_r;
        res_end_nxt   = (done_r == '0);
      end
      fca_pkg::S_FOLLOW: begin
        res_block_nxt = '0;
        res_end_nxt   = (ent == END_MARK);
        if (ent < END_MARK) begin
          res_block_nxt = fca_pkg::BLOCK_W'(ent_succ);
        end
      end
      fca_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_block_nxt  = res_block_r;
          out_count_nxt  = res_count_r;
          out_end_nxt    = res_end_r;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  assign byp_nxt      = ram_we && (ram_waddr == ram_raddr);
  assign byp_data_nxt = ram_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fca_pkg::S_CLEAR;
      idx_r       <= '0;
      max_r       <= fca_pkg::MAX_CHAIN_RST;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      byp_r       <= byp_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    first_r      <= first_nxt;
    count_r      <= count_nxt;
    done_r       <= done_nxt;
    freed_r      <= freed_nxt;
    steps_r      <= steps_nxt;
    byp_data_r   <= byp_data_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    res_count_r  <= res_count_nxt;
    res_end_r    <= res_end_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_count_r  <= out_count_nxt;
    out_end_r    <= out_end_nxt;
  end

endmodule

@@ rtl/core/fca_checker.sv @@
// Port-level assertions of the chain allocator and their bind.
`timescale 1ns / 1ps

module fca_checker (
  input logic       clk,
  input logic       rst_n,
  fca_req_if.sink   in_req,
  fca_rsp_if.source out_rsp
);

  // Hold a stalled result and its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(out_rsp.status)
      && $stable(out_rsp.block_out) && $stable(out_rsp.count_out)
      && $stable(out_rsp.chain_end))
    else $error("stalled response changed");

  // Drop ready for the clearing pass after reset.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_req.ready)
    else $error("request taken during clearing pass");

  // One request in flight: ready drops after each accepted transaction.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("second request accepted while busy");

  // A rejected allocate links nothing.
  a_overmax: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.status == fca_pkg::STATUS_OVERMAX |->
      out_rsp.count_out == '0 && out_rsp.chain_end && out_rsp.block_out == '0)
    else $error("over-maximum response carries data");

  // An empty chain or end mark reports no block.
  a_end_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.chain_end |-> out_rsp.block_out == '0)
    else $error("chain end with nonzero block");

endmodule

bind fat_chain_allocator_top fca_checker u_fca_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_req  (in_req),
  .out_rsp (out_rsp)
);
